FILE: hw/rtl/cpg_pkg.sv
`default_nettype none

package cpg_pkg;

  localparam int COORD_BITS = 10;
  localparam int PIX_BITS   = COORD_BITS + 2;
  localparam int DEC_BITS   = COORD_BITS + 4;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int PIXELS_PER_STEP = 8;
  localparam int IDX_BITS        = $clog2(PIXELS_PER_STEP);
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(PIXELS_PER_STEP - 1);

  localparam logic [DEC_BITS-1:0] DEC_INIT_BIAS = DEC_BITS'(3);
  localparam logic [DEC_BITS-1:0] DEC_INC_NEG   = DEC_BITS'(6);
  localparam logic [DEC_BITS-1:0] DEC_INC_POS   = DEC_BITS'(10);

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  // One octant step handed from the front to the pixel emitter
  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] ox;
    logic [COORD_BITS-1:0] oy;
    logic                  done;
  } step_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cpg_if.sv
`default_nettype none

interface cpg_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [cpg_pkg::COORD_BITS-1:0]    center_x;
  logic [cpg_pkg::COORD_BITS-1:0]    center_y;
  logic [cpg_pkg::COORD_BITS-1:0]    radius;

  modport source (output valid, operation, center_x, center_y, radius, input ready);
  modport sink   (input valid, operation, center_x, center_y, radius, output ready);
endinterface

interface cpg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cpg_pkg::PIX_BITS-1:0] pixel_x;
  logic signed [cpg_pkg::PIX_BITS-1:0] pixel_y;
  logic                                last_of_step;
  logic                                circle_done;

  modport source (output valid, pixel_x, pixel_y, last_of_step, circle_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_of_step, circle_done, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cpg_front.sv
`default_nettype none

module cpg_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  cpg_in_if.sink                in_ch,
  input  wire logic             q_full,
  output      logic             q_push,
  output      cpg_pkg::step_t   q_data
);

  localparam int CB = cpg_pkg::COORD_BITS;
  localparam int PB = cpg_pkg::PIX_BITS;
  localparam int DB = cpg_pkg::DEC_BITS;

  logic [CB-1:0] cx_r, cy_r, ox_r, oy_r;
  logic [DB-1:0] dec_r;
  logic          active_r;

  logic          accept, is_start;
  logic [CB-1:0] cx, cy, ox, oy;
  logic [DB-1:0] dec, dec_init, dec_nxt;
  logic [CB:0]   x1;
  logic signed [PB-1:0] y1;
  logic [DB-1:0] x1_d, y1_d;
  logic          dec_neg, done;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_start    = (in_ch.operation == cpg_pkg::OP_START);

  assign dec_init = cpg_pkg::DEC_INIT_BIAS
                  - {{(DB-CB-1){1'b0}}, in_ch.radius, 1'b0};

  always_comb begin
    if (is_start) begin
      cx  = in_ch.center_x;
      cy  = in_ch.center_y;
      ox  = '0;
      oy  = in_ch.radius;
      dec = dec_init;
    end else begin
      cx  = cx_r;
      cy  = cy_r;
      ox  = ox_r;
      oy  = oy_r;
      dec = dec_r;
    end
  end

  // Advance offsets and decision value for the step after this one
  always_comb begin
    dec_neg = dec[DB-1];
    x1      = {1'b0, ox} + (CB+1)'(1);
    y1      = $signed({2'b00, oy}) - (dec_neg ? PB'(0) : PB'(1));
    x1_d    = {{(DB-CB-1){1'b0}}, x1};
    y1_d    = {{(DB-PB){y1[PB-1]}}, y1};
    if (dec_neg) begin
      dec_nxt = dec + (x1_d << 2) + cpg_pkg::DEC_INC_NEG;
    end else begin
      dec_nxt = dec + ((x1_d - y1_d) << 2) + cpg_pkg::DEC_INC_POS;
    end
    done = $signed({1'b0, x1}) > y1;
  end

  assign q_push      = accept && (is_start || active_r);
  assign q_data.cx   = cx;
  assign q_data.cy   = cy;
  assign q_data.ox   = ox;
  assign q_data.oy   = oy;
  assign q_data.done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      ox_r     <= '0;
      oy_r     <= '0;
      dec_r    <= '0;
      active_r <= 1'b0;
    end else if (q_push) begin
      cx_r     <= cx;
      cy_r     <= cy;
      ox_r     <= x1[CB-1:0];
      oy_r     <= y1[CB-1:0];
      dec_r    <= dec_nxt;
      active_r <= !done;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cpg_step_fifo.sv
`default_nettype none

module cpg_step_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire cpg_pkg::step_t  push_data,
  input  wire logic            pop,
  output      cpg_pkg::step_t  pop_data,
  output      logic            full,
  output      logic            not_empty
);

  localparam int DEPTH = cpg_pkg::FIFO_DEPTH;
  localparam int AW    = cpg_pkg::FIFO_AW;

  cpg_pkg::step_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [AW:0]    count_r;

  assign full      = (count_r == (AW+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cpg_back.sv
`default_nettype none

module cpg_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_not_empty,
  input  wire cpg_pkg::step_t  q_data,
  output      logic            q_pop,
  cpg_out_if.source            out_ch
);

  localparam int CB = cpg_pkg::COORD_BITS;
  localparam int PB = cpg_pkg::PIX_BITS;
  localparam int IB = cpg_pkg::IDX_BITS;

  cpg_pkg::step_t cur_r;
  logic           busy_r;
  logic [IB-1:0]  idx_r;

  logic                 out_valid_r;
  logic signed [PB-1:0] pixel_x_r, pixel_y_r;
  logic                 last_r, done_r;

  logic          out_take, emit, at_last;
  logic [CB-1:0] a, b;
  logic [PB-1:0] cx_p, cy_p, a_p, b_p, px, py;

  assign out_take = !out_valid_r || out_ch.ready;
  assign emit     = busy_r && out_take;
  assign at_last  = (idx_r == cpg_pkg::LAST_IDX);
  assign q_pop    = q_not_empty && (!busy_r || (emit && at_last));

  // Index bit 2 swaps the offsets, bit 0 negates the column term, bit 1 the row term
  always_comb begin
    a    = idx_r[2] ? cur_r.oy : cur_r.ox;
    b    = idx_r[2] ? cur_r.ox : cur_r.oy;
    cx_p = {2'b00, cur_r.cx};
    cy_p = {2'b00, cur_r.cy};
    a_p  = {2'b00, a};
    b_p  = {2'b00, b};
    px   = idx_r[0] ? cx_p - a_p : cx_p + a_p;
    py   = idx_r[1] ? cy_p - b_p : cy_p + b_p;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (emit) begin
      pixel_x_r <= $signed(px);
      pixel_y_r <= $signed(py);
      last_r    <= at_last;
      done_r    <= at_last && cur_r.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (emit && at_last) begin
        busy_r <= 1'b0;
      end else if (emit) begin
        idx_r  <= idx_r + IB'(1);
      end
      if (out_take) begin
        out_valid_r <= busy_r;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = pixel_x_r;
  assign out_ch.pixel_y      = pixel_y_r;
  assign out_ch.last_of_step = last_r;
  assign out_ch.circle_done  = done_r;

endmodule

`default_nettype wire

FILE: hw/rtl/circle_pixel_generator_top.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    operation, center_x, center_y, radius
// out_ch    out  valid/ready    pixel_x, pixel_y, last_of_step, circle_done
//
// A step item leaves as eight pixel transactions, one per cycle while out_ch is ready,
// all formed by the single pixel adder pair in the emitter.
// The front takes one item per cycle while the four-entry step queue has room;
// an advance with no circle in progress is taken and dropped.
// Reset is synchronous, active low; it clears the circle and empties the queue.
// A stalled out_ch holds its pixel and backs up into the queue, then into in_ch.
`default_nettype none

module circle_pixel_generator_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cpg_in_if.sink     in_ch,
  cpg_out_if.source  out_ch
);

  logic           q_push, q_pop, q_full, q_not_empty;
  cpg_pkg::step_t q_wdata, q_rdata;

  cpg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  cpg_step_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  cpg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire
